>>> sv/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int NUM_HASH = 8;
  localparam int BLK_WORDS = 16;
  localparam int ROUNDS = 64;

  localparam logic [31:0] INIT_DEFAULT [NUM_HASH] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int PAD_LIMIT = 56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take_byte;   // write input byte, count it
    logic msg_start;   // load hash from init words
    logic pad_byte;    // write pad/zero byte at pos
    logic pad_first;   // 0x80 instead of zero
    logic put_len;     // write length words
    logic load;        // start compression
    logic round;       // one round
    logic fold;        // add into hash
    logic msg_done;    // clear length
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [5:0] byte_count;
    logic [5:0] round_idx;
  } status_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> sv/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer: byte intake, padding, rounds and digest readout.
// ----------------------------------------------------------------------------
module sha_ctrl import sha_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          in_byte_valid,
  input  logic          in_eom,
  input  status_t       stat,
  output cmd_t          cmd,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [2:0]    out_idx
);

  state_t     state_r, state_nxt;
  logic       active_r, active_nxt;
  logic       final_r, final_nxt;     // padding done, next block is last
  logic       padded_r, padded_nxt;   // 0x80 already placed
  logic [2:0] idx_r, idx_nxt;
  logic       acc;

  assign acc = in_tvalid && in_tready;
  assign out_idx = idx_r;

  always_comb begin
    state_nxt = state_r;
    active_nxt = active_r;
    final_nxt = final_r;
    padded_nxt = padded_r;
    idx_nxt = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (acc && (in_byte_valid || in_eom)) begin
          active_nxt = 1'b1;
          if (in_byte_valid && stat.byte_count == 6'd63) begin
            state_nxt = ST_LOAD;
            final_nxt = 1'b0;
            padded_nxt = 1'b0;
          end else if (in_eom) begin
            state_nxt = ST_PAD;
            padded_nxt = 1'b0;
          end
          if (in_eom) final_nxt = 1'b0;
        end
        // full block with eom pending: remember to pad afterwards
        if (acc && in_byte_valid && in_eom && stat.byte_count == 6'd63) begin
          final_nxt = 1'b1;  // reused as "pad pending" before padding
        end
      end
      ST_PAD: begin
        padded_nxt = 1'b1;
        if (stat.byte_count == 6'd63) begin
          state_nxt = ST_LOAD;
          final_nxt = 1'b0;
        end else if (padded_r && stat.byte_count == 6'(PAD_LIMIT) && !final_r) begin
          state_nxt = ST_LOAD;
          final_nxt = 1'b1;
        end else if (!padded_r && stat.byte_count >= 6'(PAD_LIMIT - 1)) begin
          final_nxt = 1'b0;
        end
      end
      ST_LOAD: state_nxt = ST_ROUND;
      ST_ROUND: if (stat.round_idx == 6'(ROUNDS - 1)) state_nxt = ST_FOLD;
      ST_FOLD: begin
        if (final_r && padded_r) begin
          state_nxt = ST_OUT;
          idx_nxt = '0;
        end else if (final_r || padded_r) begin
          state_nxt = ST_PAD;
          final_nxt = 1'b0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: if (out_tready) begin
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'(NUM_HASH - 1)) begin
          state_nxt = ST_IDLE;
          active_nxt = 1'b0;
          final_nxt = 1'b0;
          padded_nxt = 1'b0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_tready = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_OUT);
    case (state_r)
      ST_IDLE: if (acc && (in_byte_valid || in_eom)) begin
        cmd.msg_start = !active_r;
        cmd.take_byte = in_byte_valid;
      end
      ST_PAD: begin
        if (padded_r && stat.byte_count == 6'(PAD_LIMIT) && !final_r
            && stat.byte_count != 6'd63) begin
          cmd.put_len = 1'b1;
        end else begin
          cmd.pad_byte = 1'b1;
          cmd.pad_first = !padded_r;
        end
      end
      ST_LOAD: cmd.load = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_FOLD: cmd.fold = 1'b1;
      ST_OUT: if (out_tready && idx_r == 3'(NUM_HASH - 1)) cmd.msg_done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      active_r <= 1'b0;
      final_r <= 1'b0;
      padded_r <= 1'b0;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      active_r <= active_nxt;
      final_r <= final_nxt;
      padded_r <= padded_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

>>> sv/sha_dp.sv
// ----------------------------------------------------------------------------
// sha_dp
// Block buffer, length counter, schedule window and one-round datapath.
// ----------------------------------------------------------------------------
module sha_dp import sha_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  cmd_t          cmd,
  input  logic [7:0]    data_byte,
  input  logic [31:0]   init_hash [NUM_HASH],
  input  logic [2:0]    rd_idx,
  output logic [31:0]   digest_word,
  output status_t       stat
);

  logic [31:0] buf_r [BLK_WORDS];
  logic [31:0] win_r [BLK_WORDS];
  logic [31:0] hash_r [NUM_HASH];
  logic [31:0] v_r [NUM_HASH];
  logic [5:0]  cnt_r;
  logic [63:0] bits_r;
  logic [5:0]  rnd_r;

  logic [7:0]  wbyte;
  logic        wr;
  logic [31:0] w, s0, s1, t1, t2, ch, maj, se, sa;
  logic [31:0] wnew;

  assign stat.byte_count = cnt_r;
  assign stat.round_idx = rnd_r;
  assign digest_word = hash_r[rd_idx];

  assign wr = cmd.take_byte || cmd.pad_byte;
  assign wbyte = cmd.take_byte ? data_byte : (cmd.pad_first ? PAD_BYTE : 8'h00);

  // window holds the next 16 words; slot 0 is this round's word
  assign s0 = rotr(win_r[1], 7) ^ rotr(win_r[1], 18) ^ (win_r[1] >> 3);
  assign s1 = rotr(win_r[14], 17) ^ rotr(win_r[14], 19) ^ (win_r[14] >> 10);
  assign wnew = s1 + win_r[9] + s0 + win_r[0];
  assign w = win_r[0];
  assign se = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
  assign ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign sa = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1 = v_r[7] + se + ch + ROUND_K[rnd_r] + w;
  assign t2 = sa + maj;

  always_ff @(posedge clk) begin
    if (wr) begin
      case (cnt_r[1:0])
        2'd0: buf_r[cnt_r[5:2]][31:24] <= wbyte;
        2'd1: buf_r[cnt_r[5:2]][23:16] <= wbyte;
        2'd2: buf_r[cnt_r[5:2]][15:8] <= wbyte;
        default: buf_r[cnt_r[5:2]][7:0] <= wbyte;
      endcase
    end
    if (cmd.put_len) begin
      buf_r[14] <= bits_r[63:32];
      buf_r[15] <= bits_r[31:0];
    end
    if (cmd.load) begin
      win_r <= buf_r;
      v_r <= hash_r;
    end
    if (cmd.round) begin
      for (int i = 0; i < BLK_WORDS - 1; i++) win_r[i] <= win_r[i + 1];
      win_r[BLK_WORDS - 1] <= wnew;
      for (int i = 1; i < NUM_HASH; i++) begin
        if (i != 4) v_r[i] <= v_r[i - 1];
      end
      v_r[4] <= v_r[3] + t1;
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= INIT_DEFAULT;
      cnt_r <= '0;
      bits_r <= '0;
      rnd_r <= '0;
    end else begin
      if (cmd.msg_start) begin
        hash_r <= init_hash;
        bits_r <= cmd.take_byte ? 64'd8 : 64'd0;
        cnt_r <= cmd.take_byte ? 6'd1 : 6'd0;
      end else if (cmd.take_byte) begin
        bits_r <= bits_r + 64'd8;
        cnt_r <= cnt_r + 6'd1;
      end else if (cmd.pad_byte) begin
        cnt_r <= cnt_r + 6'd1;
      end else if (cmd.put_len) begin
        cnt_r <= '0;
      end
      if (cmd.load) rnd_r <= '0;
      else if (cmd.round) rnd_r <= rnd_r + 6'd1;
      if (cmd.fold) begin
        for (int i = 0; i < NUM_HASH; i++) hash_r[i] <= hash_r[i] + v_r[i];
      end
      if (cmd.msg_done) begin
        bits_r <= '0;
        cnt_r <= '0;
      end
    end
  end

endmodule

>>> sv/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher
// SHA-256 over a byte stream with configurable initial hash words.
// ----------------------------------------------------------------------------
// in_* stream: one request per byte; tuser carries byte_valid and
// end_of_message. A request with neither flag set is dropped. A byte that
// fills a 64-byte block is taken, then in_tready stays low while the block
// is compressed (load, 64 rounds, fold); other bytes without end_of_message
// leave it high. End of message writes one padding byte per cycle, then the
// length words, and takes one or two block compressions; then eight digest
// words leave on out_*, index zero first, tlast on the eighth. in_tready is
// low during padding, compression and digest output; a stalled out_tready
// holds the current word. cfg_* writes initial hash word cfg_index (0..7),
// and a write takes effect at the next message start. Reset restores the
// standard initial words and clears all counters.
// ----------------------------------------------------------------------------
module sha256_message_hasher import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic [1:0]  in_tuser,   // [0] byte_valid, [1] end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index
  output logic        out_tlast,  // last_word
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] init_r [NUM_HASH];
  cmd_t        cmd;
  status_t     stat;
  logic [2:0]  idx;
  logic [31:0] dword;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= INIT_DEFAULT;
    end else if (cfg_valid) begin
      init_r[cfg_index] <= cfg_data;
    end
  end

  sha_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_byte_valid(in_tuser[0]), .in_eom(in_tuser[1]),
    .stat(stat), .cmd(cmd),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_idx(idx)
  );

  sha_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .data_byte(in_tdata),
    .init_hash(init_r), .rd_idx(idx), .digest_word(dword), .stat(stat)
  );

  assign out_tdata = {5'd0, idx, dword};
  assign out_tlast = (idx == 3'(NUM_HASH - 1));

endmodule
